@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define PTRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define PTRT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/ptrt_pkg.sv @@
package ptrt_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int CMD_W     = 3;
  localparam int SLOT_W    = 3;
  localparam int TIME_W    = 16;
  localparam int FIRE_W    = 8;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CMP_W     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_CREATE  = 3'd1,
    CMD_SUSPEND = 3'd2,
    CMD_RESUME  = 3'd3,
    CMD_DELETE  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first_delay;
    logic [FIRE_W-1:0] fire_mask;
    logic              create_status;
  } tok_t;

endpackage

@@ rtl/ptrt_cell.sv @@
module ptrt_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ptrt_pkg::IDX_W-1:0]   idx,
  input  logic                         adv,
  input  logic                         in_vld,
  input  ptrt_pkg::tok_t               in_tok,
  output logic                         out_vld,
  output ptrt_pkg::tok_t               out_tok
);
  import ptrt_pkg::*;

  logic              valid_r, valid_nxt;
  logic              resumed_r, resumed_nxt;
  logic [TIME_W-1:0] period_r, period_nxt;
  logic [TIME_W-1:0] delay_r, delay_nxt;
  logic              vld_r;
  tok_t              tok_r, tok_nxt;
  logic              hit;

  assign hit = (CMP_W'(in_tok.slot) == CMP_W'(idx));

  always_comb begin
    valid_nxt   = valid_r;
    resumed_nxt = resumed_r;
    period_nxt  = period_r;
    delay_nxt   = delay_r;
    tok_nxt     = in_tok;
    unique case (cmd_t'(in_tok.cmd))
      CMD_TICK: begin
        if (resumed_r) begin
          if (delay_r == '0) begin
            if (valid_r) begin
              tok_nxt.fire_mask = in_tok.fire_mask | (FIRE_W'(1) << idx);
              delay_nxt         = period_r - TIME_W'(1);
            end
          end else begin
            delay_nxt = delay_r - TIME_W'(1);
          end
        end
      end
      CMD_CREATE: begin
        if (hit) begin
          if (valid_r) begin
            tok_nxt.create_status = 1'b1;
          end else begin
            period_nxt  = in_tok.period;
            delay_nxt   = in_tok.first_delay;
            valid_nxt   = 1'b1;
            resumed_nxt = 1'b1;
          end
        end
      end
      CMD_SUSPEND: begin
        if (hit) begin
          resumed_nxt = 1'b0;
        end
      end
      CMD_RESUME: begin
        if (hit) begin
          resumed_nxt = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (hit) begin
          valid_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      resumed_r <= 1'b0;
      period_r  <= '0;
      delay_r   <= '0;
      vld_r     <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
      if (in_vld) begin
        valid_r   <= valid_nxt;
        resumed_r <= resumed_nxt;
        period_r  <= period_nxt;
        delay_r   <= delay_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_vld) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_tok = tok_r;

endmodule

@@ rtl/periodic_task_release_table.sv @@
// Periodic task release table: one cell per task slot, chained in slot order.
// Each command item enters the first cell and walks the chain one cell per
// cycle while the result side does not block it; every cell applies the
// command to its own slot (tick countdown and release, create, suspend,
// resume, delete) and adds its release bit to the item. The result leaves
// the last cell into an output register, and a new item is accepted only
// once the chain is empty, so an item is not taken before the previous one
// has left the chain.
module periodic_task_release_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ptrt_pkg::CMD_W-1:0]    in_cmd,
  input  logic [ptrt_pkg::SLOT_W-1:0]   in_slot,
  input  logic [ptrt_pkg::TIME_W-1:0]   in_period,
  input  logic [ptrt_pkg::TIME_W-1:0]   in_first_delay,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ptrt_pkg::FIRE_W-1:0]   out_fire_mask,
  output logic                          out_create_status
);
  import ptrt_pkg::*;
  `include "assert_macros.svh"

  logic [NUM_SLOTS:0] vld;
  tok_t               tok [NUM_SLOTS+1];
  logic               adv;
  logic               in_acc;
  logic               out_valid_r;
  logic [FIRE_W-1:0]  out_fire_mask_r;
  logic               out_create_status_r;

  assign in_stall = |vld[NUM_SLOTS:1];
  assign in_acc   = in_valid && !in_stall;
  assign adv      = !(vld[NUM_SLOTS] && out_valid_r && out_stall);

  assign vld[0]                 = in_acc;
  assign tok[0].cmd             = in_cmd;
  assign tok[0].slot            = in_slot;
  assign tok[0].period          = in_period;
  assign tok[0].first_delay     = in_first_delay;
  assign tok[0].fire_mask       = '0;
  assign tok[0].create_status   = 1'b0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    ptrt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .idx     (IDX_W'(i)),
      .adv     (adv),
      .in_vld  (vld[i]),
      .in_tok  (tok[i]),
      .out_vld (vld[i+1]),
      .out_tok (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && vld[NUM_SLOTS]) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[NUM_SLOTS]) begin
      out_fire_mask_r     <= tok[NUM_SLOTS].fire_mask;
      out_create_status_r <= tok[NUM_SLOTS].create_status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fire_mask     = out_fire_mask_r;
  assign out_create_status = out_create_status_r;

  `PTRT_ASSERT(a_one_item_in_chain, $onehot0(vld[NUM_SLOTS:1]), "more than one item in chain")
  `PTRT_ASSERT(a_accept_enters, in_acc |=> vld[1], "accepted item missing from first cell")
  `PTRT_ASSERT(a_last_holds, (vld[NUM_SLOTS] && !adv) |=> vld[NUM_SLOTS], "blocked item dropped")
  `PTRT_ASSERT(a_out_from_chain, $rose(out_valid_r) |-> $past(vld[NUM_SLOTS]), "result without item")
  `PTRT_ASSERT_ALWAYS(a_no_accept_busy, !(in_acc && (|vld[NUM_SLOTS:1])), "accept while busy")

endmodule

@@ bench/testbench.sv @@
module testbench;
  import ptrt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [FIRE_W-1:0] fire_mask;
    logic              create_status;
  } release_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] first_delay;
    logic              fixed;
    release_t          want;
  } cmd_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd;
  logic [SLOT_W-1:0]   in_slot;
  logic [TIME_W-1:0]   in_period;
  logic [TIME_W-1:0]   in_first_delay;
  logic                out_valid;
  logic                out_stall;
  logic [FIRE_W-1:0]   out_fire_mask;
  logic                out_create_status;

  logic                task_valid [NUM_SLOTS];
  logic                task_running [NUM_SLOTS];
  logic [TIME_W-1:0]   task_period [NUM_SLOTS];
  logic [TIME_W-1:0]   task_delay [NUM_SLOTS];

  release_t            release_q [$];
  cmd_row_t            directed_rows [$];
  int                  mismatch_count = 0;
  int                  cycle_count = 0;
  bit                  calm;
  bit                  hold_off_req;

  periodic_task_release_table dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_slot           (in_slot),
    .in_period         (in_period),
    .in_first_delay    (in_first_delay),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fire_mask     (out_fire_mask),
    .out_create_status (out_create_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic release_t apply_cmd(input cmd_row_t r);
    release_t res;
    res = '0;
    if (r.cmd == CMD_TICK) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (task_running[i]) begin
          if (task_delay[i] == '0) begin
            if (task_valid[i]) begin
              res.fire_mask[i] = 1'b1;
              task_delay[i] = task_period[i] - 16'd1;
            end
          end else begin
            task_delay[i] = task_delay[i] - 16'd1;
          end
        end
      end
    end else if (r.slot < NUM_SLOTS) begin
      case (r.cmd)
        CMD_CREATE: begin
          if (task_valid[r.slot]) begin
            res.create_status = 1'b1;
          end else begin
            task_period[r.slot] = r.period;
            task_delay[r.slot] = r.first_delay;
            task_valid[r.slot] = 1'b1;
            task_running[r.slot] = 1'b1;
          end
        end
        CMD_SUSPEND: task_running[r.slot] = 1'b0;
        CMD_RESUME:  task_running[r.slot] = 1'b1;
        CMD_DELETE:  task_valid[r.slot] = 1'b0;
        default: ;
      endcase
    end
    return res;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                         input logic [TIME_W-1:0] period, input logic [TIME_W-1:0] dly,
                         input logic fixed, input logic [FIRE_W-1:0] mask,
                         input logic status);
    cmd_row_t r;
    r.cmd = cmd;
    r.slot = slot;
    r.period = period;
    r.first_delay = dly;
    r.fixed = fixed;
    r.want.fire_mask = mask;
    r.want.create_status = status;
    directed_rows.push_back(r);
  endtask

  function automatic cmd_row_t random_row();
    cmd_row_t r;
    int pick;
    pick = $urandom_range(0, 99);
    r.fixed = 1'b0;
    r.want = '0;
    r.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    r.period = TIME_W'($urandom);
    r.first_delay = TIME_W'($urandom);
    if (pick < 45) begin
      r.cmd = CMD_TICK;
    end else if (pick < 67) begin
      r.cmd = CMD_CREATE;
      if ($urandom_range(0, 4) != 0) begin
        r.period = TIME_W'($urandom_range(0, 6));
        r.first_delay = TIME_W'($urandom_range(0, 6));
      end
    end else if (pick < 77) begin
      r.cmd = CMD_SUSPEND;
    end else if (pick < 87) begin
      r.cmd = CMD_RESUME;
    end else if (pick < 96) begin
      r.cmd = CMD_DELETE;
    end else begin
      r.cmd = CMD_W'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
    end
    return r;
  endfunction

  task automatic issue(input cmd_row_t r, input bit allow_gap);
    int gap;
    release_t predicted;
    gap = 0;
    if (allow_gap && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= r.cmd;
    in_slot <= r.slot;
    in_period <= r.period;
    in_first_delay <= r.first_delay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_cmd(r);
    release_q.push_back(r.fixed ? r.want : predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (release_q.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && rst_n && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    release_t got;
    release_t want;
    got.fire_mask = out_fire_mask;
    got.create_status = out_create_status;
    if (rst_n && out_valid && !out_stall) begin
      if (release_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected item: fire_mask=%h create_status=%b",
                   got.fire_mask, got.create_status);
      end else begin
        want = release_q.pop_front();
        if (got.fire_mask !== want.fire_mask || got.create_status !== want.create_status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: fire_mask exp %h got %h, create_status exp %b got %b",
                     want.fire_mask, got.fire_mask, want.create_status,
                     got.create_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_TICK;
    in_slot = '0;
    in_period = '0;
    in_first_delay = '0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      task_valid[i] = 1'b0;
      task_running[i] = 1'b0;
      task_period[i] = '0;
      task_delay[i] = '0;
    end

    add_row(CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0);
    add_row(CMD_SUSPEND, 3'd3, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0);
    add_row(CMD_RESUME,  3'd5, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0);
    add_row(CMD_CREATE,  3'd0, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0);
    add_row(CMD_CREATE,  3'd0, 16'hFFFF, 16'hFFFF, 1'b1, 8'h00, 1'b1);
    add_row(CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b1, 8'h01, 1'b0);
    add_row(CMD_CREATE,  3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 8'h00, 1'b0);
    add_row(CMD_CREATE,  3'd1, 16'h0001, 16'h0001, 1'b1, 8'h00, 1'b0);
    add_row(CMD_TICK,    3'd7, 16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 1'b0);
    add_row(CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    add_row(CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    add_row(CMD_SPARE_5, 3'd2, 16'hFFFF, 16'hFFFF, 1'b1, 8'h00, 1'b0);
    add_row(CMD_SPARE_6, 3'd6, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0);
    add_row(CMD_SPARE_7, 3'd7, 16'hFFFF, 16'h0000, 1'b1, 8'h00, 1'b0);
    add_row(CMD_DELETE,  3'd1, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0);
    add_row(CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    add_row(CMD_CREATE,  3'd1, 16'h0002, 16'h0000, 1'b1, 8'h00, 1'b0);
    add_row(CMD_SUSPEND, 3'd1, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0);
    add_row(CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    add_row(CMD_RESUME,  3'd1, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0);
    add_row(CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    add_row(CMD_CREATE,  3'd5, 16'h0003, 16'h0000, 1'b1, 8'h00, 1'b0);
    add_row(CMD_DELETE,  3'd7, 16'h0000, 16'h0000, 1'b1, 8'h00, 1'b0);
    add_row(CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);
    add_row(CMD_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0, 8'h00, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) issue(directed_rows[i], 1'b1);

    for (int n = 0; n < 300; n++) begin
      if (n == 100) hold_off_req = 1'b1;
      issue(random_row(), 1'b1);
    end

    // hold the sender until every result is back
    drain();

    for (int n = 0; n < 250; n++) issue(random_row(), 1'b1);

    calm = 1'b1;
    for (int n = 0; n < 150; n++) issue(random_row(), 1'b0);

    drain();
    repeat (4 * (NUM_SLOTS + 1)) @(posedge clk);
    if (mismatch_count == 0 && release_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ptrt_pkg.sv
rtl/ptrt_cell.sv
rtl/periodic_task_release_table.sv
bench/testbench.sv
